### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SIT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, but also checked while reset is high.
`define SIT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/sit_pkg.sv
// Shared types and constants of the sorted insert table.
// No dependencies.
package sit_pkg;

   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 5;
   localparam int DEF_CAPACITY = 16;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_SEARCH = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      WHERE_EMPTY  = 3'd0,
      WHERE_FIRST  = 3'd1,
      WHERE_LAST   = 3'd2,
      WHERE_MIDDLE = 3'd3,
      WHERE_ABSENT = 3'd4
   } where_type;

   typedef struct packed {
      action_type               action;
      logic signed [DATA_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      where_type           where_found;
      logic [COUNT_W-1:0]  entry_count;
      logic                insert_dropped;
   } rsp_type;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic                     insert_en;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

### hw/rtl/sit_cell.sv
// One slot of the sorted table: holds an entry, compares it with the
// broadcast value and shifts toward the tail on insert. Uses sit_pkg.
module sit_cell import sit_pkg::*; #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic [CNT_W-1:0]         count,
   input  logic                     prev_take,
   input  logic signed [DATA_W-1:0] prev_entry,
   input  logic                     prev_match,
   output logic                     take,
   output logic signed [DATA_W-1:0] entry,
   output logic                     match,
   output logic                     hit_last
);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic                     occupied;

   assign occupied = CNT_W'(IDX) < count;
   // empty slots always lie past the insert point
   assign take     = !occupied || (ctrl.value <= entry_ff);
   assign match    = occupied && (entry_ff == ctrl.value);
   // first equal entry sitting in the tail slot
   assign hit_last = match && !prev_match && (count == CNT_W'(IDX + 1));
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en && take) begin
         entry_in = prev_take ? prev_entry : ctrl.value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### hw/rtl/sorted_insert_table_core.sv
// Sorted insert table: a row of CAPACITY cells keeps signed entries in
// ascending order. A new request (insert or search) is accepted each cycle;
// all cells compare against the request in parallel and shift by one slot on
// insert, and the response is registered, appearing in the cycle after the
// request is accepted. A response stalled at the output holds off the next
// request. Depends on sit_pkg and sit_cell.
module sorted_insert_table_core import sit_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept, is_insert, full;
   cell_ctrl_type    ctrl;

   logic                     take       [CAPACITY];
   logic signed [DATA_W-1:0] entry      [CAPACITY];
   logic                     match      [CAPACITY];
   logic                     hit_last   [CAPACITY];
   logic                     prev_take  [CAPACITY];
   logic signed [DATA_W-1:0] prev_entry [CAPACITY];
   logic                     prev_match [CAPACITY];
   logic [CAPACITY-1:0]      match_vec, last_vec;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_insert = req_payload.action == ACT_INSERT;
   assign full      = count_ff == CNT_W'(CAPACITY);

   assign ctrl.insert_en = accept && is_insert && !full;
   assign ctrl.value     = req_payload.item_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev_take[i]  = 1'b0;
         assign prev_entry[i] = '0;
         assign prev_match[i] = 1'b0;
      end else begin : g_link
         assign prev_take[i]  = take[i-1];
         assign prev_entry[i] = entry[i-1];
         assign prev_match[i] = match[i-1];
      end

      sit_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .prev_take  (prev_take[i]),
         .prev_entry (prev_entry[i]),
         .prev_match (prev_match[i]),
         .take       (take[i]),
         .entry      (entry[i]),
         .match      (match[i]),
         .hit_last   (hit_last[i])
      );

      assign match_vec[i] = match[i];
      assign last_vec[i]  = hit_last[i];
   end

   assign count_in = ctrl.insert_en ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      rsp_in.entry_count    = COUNT_W'(count_in);
      rsp_in.insert_dropped = is_insert && full;
      rsp_in.where_found    = WHERE_EMPTY;
      if (!is_insert) begin
         if (count_ff == '0) begin
            rsp_in.where_found = WHERE_EMPTY;
         end else if (match_vec[0]) begin
            rsp_in.where_found = WHERE_FIRST;
         end else if (match_vec == '0) begin
            rsp_in.where_found = WHERE_ABSENT;
         end else if (last_vec != '0) begin
            rsp_in.where_found = WHERE_LAST;
         end else begin
            rsp_in.where_found = WHERE_MIDDLE;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hw/rtl/sit_checker.sv
// Port-level checks for sorted_insert_table_core, bound to the top level.
// Depends on sit_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sit_checker import sit_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   `SIT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled response changed")
   `SIT_ASSERT_ALWAYS(a_no_stall_idle, clock, !rsp_valid |-> !req_stall, "request stalled with output empty")
   `SIT_ASSERT(a_transfer_rsp, clock, reset, req_valid && !req_stall |=> rsp_valid, "accepted request gave no response")
   `SIT_ASSERT(a_drop_no_where, clock, reset, rsp_valid && rsp_payload.insert_dropped |-> rsp_payload.where_found == WHERE_EMPTY, "dropped insert reports a position")

endmodule

bind sorted_insert_table_core sit_checker u_sit_checker (.*);

### dv/sorted_insert_table_core_test.sv
// Testbench for sorted_insert_table_core: inserts and searches of signed values,
// responses checked against an ordered-store prediction held in a small class.
// Depends on sit_pkg and the sorted_insert_table_core RTL.
`timescale 1ns / 100ps

class sorted_store_board;
   logic signed [sit_pkg::DATA_W-1:0] entries [sit_pkg::DEF_CAPACITY];
   int                                fill;
   sit_pkg::rsp_type                  expected_q [$];
   int                                mismatches;

   function new();
      fill       = 0;
      mismatches = 0;
   endfunction

   // Applies one accepted request to the predicted store and queues its response.
   function void note_request(sit_pkg::req_type r);
      sit_pkg::rsp_type                  exp_rsp;
      logic signed [sit_pkg::DATA_W-1:0] v;
      int                                pos;
      v                      = r.item_value;
      exp_rsp.where_found    = sit_pkg::WHERE_EMPTY;
      exp_rsp.insert_dropped = 1'b0;
      if (r.action == sit_pkg::ACT_INSERT) begin
         if (fill >= sit_pkg::DEF_CAPACITY) begin
            exp_rsp.insert_dropped = 1'b1;
         end else begin
            // goes ahead of the first entry that is >= the new value
            pos = fill;
            for (int i = 0; i < fill; i++) begin
               if (v <= entries[i]) begin
                  pos = i;
                  break;
               end
            end
            for (int i = fill; i > pos; i--)
               entries[i] = entries[i-1];
            entries[pos] = v;
            fill++;
         end
      end else if (fill != 0) begin
         exp_rsp.where_found = sit_pkg::WHERE_ABSENT;
         for (int i = 0; i < fill; i++) begin
            if (entries[i] == v) begin
               // a lone entry reports first
               if (i == 0)
                  exp_rsp.where_found = sit_pkg::WHERE_FIRST;
               else if (i == fill - 1)
                  exp_rsp.where_found = sit_pkg::WHERE_LAST;
               else
                  exp_rsp.where_found = sit_pkg::WHERE_MIDDLE;
               break;
            end
         end
      end
      exp_rsp.entry_count = fill[sit_pkg::COUNT_W-1:0];
      expected_q.push_back(exp_rsp);
   endfunction

   function void check_response(sit_pkg::rsp_type got);
      sit_pkg::rsp_type exp_rsp;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected transfer where=%0d count=%0d dropped=%0b",
                     got.where_found, got.entry_count, got.insert_dropped);
         return;
      end
      exp_rsp = expected_q.pop_front();
      if (got.where_found !== exp_rsp.where_found
          || got.entry_count !== exp_rsp.entry_count
          || got.insert_dropped !== exp_rsp.insert_dropped) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: exp where=%0d count=%0d dropped=%0b, got where=%0d count=%0d dropped=%0b",
                     exp_rsp.where_found, exp_rsp.entry_count, exp_rsp.insert_dropped,
                     got.where_found, got.entry_count, got.insert_dropped);
      end
   endfunction

   function int outstanding();
      return expected_q.size();
   endfunction
endclass

module sorted_insert_table_core_test;
   import sit_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;
   localparam int RANDOM_ITEMS   = 537;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   int      req_idle_pct;
   int      rsp_stall_pct;
   bit      hold_request;
   int      quiet_cycles;

   sorted_store_board board;

   sorted_insert_table_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #6 clock = ~clock;

   // Receiver: random stall per cycle, or one long hold when asked.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Transfer monitor and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_response(rsp_payload);
         if (req_valid && !req_stall)
            board.note_request(req_payload);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("Mismatches found");
               $finish;
            end
         end
      end
   end

   function automatic req_type build_request(action_type a, logic signed [DATA_W-1:0] v);
      req_type r;
      r.action     = a;
      r.item_value = v;
      return r;
   endfunction

   function automatic req_type random_request();
      logic signed [DATA_W-1:0] v;
      int                       pick;
      pick = $urandom_range(9);
      v    = $urandom;
      if (pick < 4) begin
         if (board.fill > 0)
            v = board.entries[$urandom_range(board.fill - 1)];
         return build_request(ACT_SEARCH, v);
      end
      if (pick == 4)
         return build_request(ACT_SEARCH, v);
      if (pick == 5) begin
         // near misses around stored values
         if (board.fill > 0)
            v = board.entries[$urandom_range(board.fill - 1)] + ($urandom_range(1) ? 1 : -1);
         return build_request(ACT_SEARCH, v);
      end
      if ($urandom_range(1)) begin
         case ($urandom_range(8))
            0: v = VAL_MIN;
            1: v = VAL_MIN + 1;
            2: v = -2;
            3: v = -1;
            4: v = 0;
            5: v = 1;
            6: v = 2;
            7: v = VAL_MAX - 1;
            default: v = VAL_MAX;
         endcase
      end
      return build_request(ACT_INSERT, v);
   endfunction

   // Offers one request, idling first at the current rate, and returns
   // at the falling edge after its transfer.
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      board       = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty search, lone entry, extremes, duplicates, each position
      send_request(build_request(ACT_SEARCH, 0));
      send_request(build_request(ACT_INSERT, 5));
      send_request(build_request(ACT_SEARCH, 5));
      send_request(build_request(ACT_SEARCH, 7));
      send_request(build_request(ACT_INSERT, VAL_MIN));
      send_request(build_request(ACT_INSERT, VAL_MAX));
      send_request(build_request(ACT_INSERT, 5));
      send_request(build_request(ACT_INSERT, 0));
      send_request(build_request(ACT_INSERT, -1));
      send_request(build_request(ACT_SEARCH, VAL_MIN));
      send_request(build_request(ACT_SEARCH, VAL_MAX));
      send_request(build_request(ACT_SEARCH, 5));
      send_request(build_request(ACT_SEARCH, 0));

      // random: store fills early, then full-store drops and searches
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case (n * 5 / RANDOM_ITEMS)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 75; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 75; end
            3: begin req_idle_pct = 10; rsp_stall_pct = 10; end
            default: begin req_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         if (n == RANDOM_ITEMS * 4 / 5)
            hold_request = 1'b1;
         send_request(random_request());
      end
      req_valid <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (board.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
